// File: hw/rtl/smi_pkg.sv
// Shared types, widths and status codes for the sorted multiset store.
`timescale 1ns / 1ps
`default_nettype none

package smi_pkg;

    localparam int ValueW    = 32;
    localparam int StatusW   = 2;
    localparam int CountOutW = 7;
    localparam int DefCapacity = 64;

    localparam logic [StatusW-1:0] ST_INSERTED = 2'd0;
    localparam logic [StatusW-1:0] ST_DELETED  = 2'd1;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [StatusW-1:0] ST_FULL     = 2'd3;

    // Operation broadcast to every cell in the update cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } ctl_t;

    // Map signed order onto unsigned order.
    function automatic logic [ValueW-1:0] order_key(input logic [ValueW-1:0] v);
        order_key = {~v[ValueW-1], v[ValueW-2:0]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sorted_multiset_insert_delete.sv
// Top level of the sorted multiset store: cell row, count and result stage.
`timescale 1ns / 1ps
`default_nettype none

// Sorted multiset store. Holds up to CAPACITY signed 32-bit values in
// ascending order in a row of cells, one value per cell. Each accepted item
// either inserts item_value ahead of any equal values (req_type 0) or removes
// one copy of it (req_type 1). The value is broadcast to all cells, each cell
// compares it with its own entry, and the cells from the insertion point or
// first copy upward shift up or down by one place in the cycle the item is
// accepted, at any capacity. Once the item is pending and the output
// register is free, the result stage reads the smallest value from the first
// cell and the largest from the last occupied cell and loads the output
// register. in_stall is high in the cycle after every accepted item, and
// stays high while the output register still holds an earlier result on a
// stalled output; no new item is taken until the last result has moved on.
// One finished result may wait on a stalled output while the next
// item is already applied to the row. Status: 0 inserted, 1 deleted, 2 not
// found (also for a delete from an empty store), 3 full (store unchanged).
// held_count is the count after the item, modulo 128 for capacities above
// 127; smallest_value and largest_value read zero when the store is empty.
// No clearing pass is needed after reset: cells above the count are never
// read.
module sorted_multiset_insert_delete #(
    parameter int CAPACITY = smi_pkg::DefCapacity
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               req_type,
    input  wire logic signed [smi_pkg::ValueW-1:0]  item_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic             [smi_pkg::StatusW-1:0] status,
    output logic           [smi_pkg::CountOutW-1:0] held_count,
    output logic signed      [smi_pkg::ValueW-1:0]  smallest_value,
    output logic signed      [smi_pkg::ValueW-1:0]  largest_value
);

    localparam int CountW = $clog2(CAPACITY+1);
    localparam int VW     = smi_pkg::ValueW;

    // Row of cells.
    logic [VW-1:0]       cell_val [CAPACITY];
    logic [VW-1:0]       cell_tap [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_match;

    // Control state.
    logic [CountW-1:0]           occ_reg;
    logic [CountW-1:0]           occ_next;
    logic                        pend_reg;
    logic                        pend_next;
    logic [smi_pkg::StatusW-1:0] pend_status_reg;
    logic [smi_pkg::StatusW-1:0] pend_status_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [smi_pkg::StatusW-1:0]   out_status_reg;
    logic [smi_pkg::CountOutW-1:0] out_count_reg;
    logic [VW-1:0]                 out_small_reg;
    logic [VW-1:0]                 out_large_reg;

    logic          in_acc;
    logic          load_out;
    logic          full;
    logic          found;
    logic [VW-1:0] largest_sel;
    smi_pkg::ctl_t ctl;

    assign in_stall = pend_reg;
    assign in_acc   = in_valid && !pend_reg;
    assign load_out = pend_reg && (!out_valid_reg || !out_stall);

    assign full  = (occ_reg == CountW'(CAPACITY));
    assign found = |cell_match;

    // Shift the row only when the operation really changes the store.
    assign ctl.ins = in_acc && !req_type && !full;
    assign ctl.del = in_acc && req_type && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic          left_lt;
            logic [VW-1:0] left_value;
            logic [VW-1:0] right_value;

            if (gi == 0)
            begin : g_first
                // Nothing to the left: treat it as smaller than anything.
                assign left_lt    = 1'b1;
                assign left_value = cell_val[gi];
            end
            else
            begin : g_inner
                assign left_lt    = cell_lt[gi-1];
                assign left_value = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_val[gi];
            end
            else
            begin : g_mid
                assign right_value = cell_val[gi+1];
            end

            smi_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (gi)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .cmd_value   (item_value),
                .occ         (occ_reg),
                .left_lt     (left_lt),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_val[gi]),
                .lt          (cell_lt[gi]),
                .match       (cell_match[gi]),
                .tap         (cell_tap[gi])
            );
        end
    endgenerate

    // Only the last occupied cell drives its tap, so an OR picks the largest.
    always_comb
    begin
        largest_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            largest_sel = largest_sel | cell_tap[i];
        end
    end

    always_comb
    begin
        occ_next         = occ_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        if (ctl.ins)
        begin
            occ_next = occ_reg + CountW'(1);
        end
        else if (ctl.del)
        begin
            occ_next = occ_reg - CountW'(1);
        end

        if (in_acc)
        begin
            pend_next = 1'b1;
            if (!req_type)
            begin
                pend_status_next = full ? smi_pkg::ST_FULL : smi_pkg::ST_INSERTED;
            end
            else
            begin
                pend_status_next = found ? smi_pkg::ST_DELETED : smi_pkg::ST_NOTFOUND;
            end
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold while the output is stalled, load when the pending item moves.
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_count_reg  <= smi_pkg::CountOutW'(occ_reg);
            if (occ_reg == '0)
            begin
                out_small_reg <= '0;
                out_large_reg <= '0;
            end
            else
            begin
                out_small_reg <= cell_val[0];
                out_large_reg <= largest_sel;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign held_count     = out_count_reg;
    assign smallest_value = out_small_reg;
    assign largest_value  = out_large_reg;

endmodule

`default_nettype wire

// File: hw/rtl/smi_cell.sv
// One cell of the sorted row: holds one value and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module smi_cell #(
    parameter int CAPACITY = smi_pkg::DefCapacity,
    parameter int IDX      = 0
) (
    input  wire logic                        clk,
    input  wire smi_pkg::ctl_t               ctl,
    input  wire logic [smi_pkg::ValueW-1:0]  cmd_value,
    input  wire logic [$clog2(CAPACITY+1)-1:0] occ,
    input  wire logic                        left_lt,
    input  wire logic [smi_pkg::ValueW-1:0]  left_value,
    input  wire logic [smi_pkg::ValueW-1:0]  right_value,
    output logic      [smi_pkg::ValueW-1:0]  value,
    output logic                             lt,
    output logic                             match,
    output logic      [smi_pkg::ValueW-1:0]  tap
);

    localparam int CountW = $clog2(CAPACITY+1);

    logic [smi_pkg::ValueW-1:0] value_reg;
    logic [smi_pkg::ValueW-1:0] value_next;
    logic                       occupied;
    logic                       last;

    assign occupied = CountW'(IDX) < occ;
    assign last     = occupied && (CountW'(IDX + 1) == occ);
    assign lt       = occupied &&
                      (smi_pkg::order_key(value_reg) < smi_pkg::order_key(cmd_value));
    assign match    = occupied && (value_reg == cmd_value);
    assign value    = value_reg;
    assign tap      = last ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins)
        begin
            // Keep smaller values, drop the new one in at the boundary, shift the rest up.
            if (!lt)
            begin
                value_next = left_lt ? cmd_value : left_value;
            end
        end
        else if (ctl.del)
        begin
            // Everything from the first copy upward pulls in its right neighbor.
            if (!lt)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/smi_checker.sv
// Port-level checks for the sorted multiset store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smi_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               req_type,
    input wire logic signed [smi_pkg::ValueW-1:0]  item_value,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic             [smi_pkg::StatusW-1:0] status,
    input wire logic           [smi_pkg::CountOutW-1:0] held_count,
    input wire logic signed      [smi_pkg::ValueW-1:0]  smallest_value,
    input wire logic signed      [smi_pkg::ValueW-1:0]  largest_value
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(held_count)
            && $stable(smallest_value) && $stable(largest_value))
        else $error("stalled result changed");

    // After an accepted item the block holds off for the result read-out.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item still pending");

    // Held values are ordered.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held_count != '0 |-> smallest_value <= largest_value)
        else $error("smallest exceeds largest");

    // A full or not-found result leaves the store as it was, so the count repeats.
    a_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && !out_stall
            && (status == smi_pkg::ST_FULL || status == smi_pkg::ST_NOTFOUND)
            |-> held_count == $past(held_count))
        else $error("refused item changed the count");

endmodule

bind sorted_multiset_insert_delete smi_checker u_smi_checker (.*);

`default_nettype wire
